// ----- src/keyed_recency_order_list_macros.svh -----
// Assertion macros used by the checker file of the keyed recency list.
// Bodies use the clk and rst names of the scope that expands them.
`ifndef KEYED_RECENCY_ORDER_LIST_MACROS_SVH
`define KEYED_RECENCY_ORDER_LIST_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define KROL_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("keyed recency list check failed");

// Next-cycle implication, disabled while reset is high.
`define KROL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("keyed recency list check failed");

`endif

// ----- src/krol_pkg.sv -----
// Shared types and constants for the keyed recency order list.
// Used by the controller, the datapath, the top level and the checker.
package krol_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int KEY_BITS_DEF = 32;
  localparam int KEY_W        = 32;
  localparam int COUNT_W      = 5;

  typedef enum logic [2:0] {
    OP_INS_HEAD = 3'd0,
    OP_INS_TAIL = 3'd1,
    OP_REMOVE   = 3'd2,
    OP_POP_HEAD = 3'd3,
    OP_POP_TAIL = 3'd4,
    OP_TO_HEAD  = 3'd5,
    OP_TO_TAIL  = 3'd6,
    OP_CLEAR    = 3'd7
  } opcode_t;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef struct packed {
    opcode_t                   opcode;
    logic signed [KEY_W-1:0]   key;
  } req_beat_t;

  typedef struct packed {
    status_t                   status;
    logic        [COUNT_W-1:0] entry_count;
    logic signed [KEY_W-1:0]   head_key;
    logic signed [KEY_W-1:0]   tail_key;
  } rsp_beat_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;     // capture the request beat
    logic compare;  // compare key against every slot
    logic exec;     // apply the operation to the list
    logic publish;  // load the response register from the list
  } krol_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic rsp_valid;
  } krol_sts_t;

endpackage

// ----- src/krol_ctrl.sv -----
// Sequencing controller for the keyed recency order list.
// Depends on krol_pkg for the command and status structs.
module krol_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  logic                rsp_ready,
  input  krol_pkg::krol_sts_t sts,
  output krol_pkg::krol_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_COMPARE,
    S_EXEC
  } state_t;

  state_t state;
  state_t state_next;
  logic   publish;
  logic   out_free;

  // The response register will be empty by the next edge.
  assign out_free  = !sts.rsp_valid || rsp_ready;
  assign req_ready = (state == S_IDLE) || ((state == S_EXEC) && out_free);

  always_comb begin
    cmd.load    = req_valid && req_ready;
    cmd.compare = (state == S_COMPARE);
    cmd.exec    = (state == S_EXEC) && out_free;
    cmd.publish = publish;
    state_next  = state;
    case (state)
      S_IDLE: begin
        if (cmd.load) state_next = S_COMPARE;
      end
      S_COMPARE: begin
        state_next = S_EXEC;
      end
      S_EXEC: begin
        if (out_free) state_next = cmd.load ? S_COMPARE : S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      publish <= 1'b0;
    end else begin
      state   <= state_next;
      publish <= cmd.exec;
    end
  end

endmodule

// ----- src/krol_datapath.sv -----
// Slot shift line, parallel key compare and response register.
// Depends on krol_pkg for beat types, opcodes and command structs.
module krol_datapath #(
  parameter int CAPACITY = krol_pkg::CAPACITY_DEF,
  parameter int KEY_BITS = krol_pkg::KEY_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  krol_pkg::krol_cmd_t   cmd,
  output krol_pkg::krol_sts_t   sts,
  input  krol_pkg::req_beat_t   req,
  output krol_pkg::rsp_beat_t   rsp,
  input  logic                  rsp_ready
);

  localparam int CW           = $clog2(CAPACITY + 1);
  localparam int PREFIX_STEPS = $clog2(CAPACITY);

  krol_pkg::opcode_t op_q;
  logic [KEY_BITS-1:0] key_q;
  logic [KEY_BITS-1:0] slots [CAPACITY];
  logic [KEY_BITS-1:0] slots_next [CAPACITY];
  logic [CW-1:0]       count;
  logic [CW-1:0]       count_next;
  logic [CW-1:0]       last_idx;
  logic [CAPACITY-1:0] match_raw;
  logic [CAPACITY-1:0] match_q;
  logic                tail_eq_raw;
  logic                tail_eq_q;
  logic [CAPACITY-1:0] ge;
  logic [CAPACITY-1:0] gt;
  logic                found;
  logic                full;
  logic                empty;
  krol_pkg::status_t   status_next;
  krol_pkg::status_t   status_q;
  logic [KEY_BITS-1:0] tail_sel;
  logic                rsp_valid;

  assign last_idx = CW'(count - CW'(1));
  assign full     = count >= CW'(CAPACITY);
  assign empty    = (count == '0);
  assign sts.rsp_valid = rsp_valid;

  // Compare every occupied slot against the held key.
  always_comb begin
    tail_eq_raw = 1'b0;
    for (int i = 0; i < CAPACITY; i++) begin
      match_raw[i] = (slots[i] == key_q) && (CW'(i) < count);
      if (CW'(i) == last_idx) tail_eq_raw = tail_eq_raw | match_raw[i];
    end
  end

  // Apply the operation: masks mark slots at or after the first match.
  always_comb begin
    ge = match_q;
    for (int s = 0; s < PREFIX_STEPS; s++) ge = ge | (ge << (1 << s));
    gt          = ge << 1;
    found       = |match_q;
    slots_next  = slots;
    count_next  = count;
    status_next = krol_pkg::ST_DONE;
    case (op_q)
      krol_pkg::OP_INS_HEAD: begin
        if (full) begin
          status_next = krol_pkg::ST_FULL;
        end else begin
          slots_next[0] = key_q;
          for (int i = 1; i < CAPACITY; i++) slots_next[i] = slots[i-1];
          count_next = CW'(count + CW'(1));
        end
      end
      krol_pkg::OP_INS_TAIL: begin
        if (full) begin
          status_next = krol_pkg::ST_FULL;
        end else begin
          for (int i = 0; i < CAPACITY; i++) begin
            if (CW'(i) == count) slots_next[i] = key_q;
          end
          count_next = CW'(count + CW'(1));
        end
      end
      krol_pkg::OP_REMOVE: begin
        if (!found) begin
          status_next = krol_pkg::ST_MISS;
        end else begin
          for (int i = 0; i < CAPACITY - 1; i++) begin
            if (ge[i]) slots_next[i] = slots[i+1];
          end
          count_next = last_idx;
        end
      end
      krol_pkg::OP_POP_HEAD: begin
        if (empty) begin
          status_next = krol_pkg::ST_MISS;
        end else begin
          for (int i = 0; i < CAPACITY - 1; i++) slots_next[i] = slots[i+1];
          count_next = last_idx;
        end
      end
      krol_pkg::OP_POP_TAIL: begin
        if (empty) status_next = krol_pkg::ST_MISS;
        else count_next = last_idx;
      end
      krol_pkg::OP_TO_HEAD: begin
        if (empty) begin
          status_next = krol_pkg::ST_MISS;
        end else if (!match_q[0]) begin
          if (!found) begin
            status_next = krol_pkg::ST_MISS;
          end else begin
            slots_next[0] = key_q;
            for (int i = 1; i < CAPACITY; i++) begin
              if (!gt[i]) slots_next[i] = slots[i-1];
            end
          end
        end
      end
      krol_pkg::OP_TO_TAIL: begin
        if (empty) begin
          status_next = krol_pkg::ST_MISS;
        end else if (!tail_eq_q) begin
          if (!found) begin
            status_next = krol_pkg::ST_MISS;
          end else begin
            for (int i = 0; i < CAPACITY - 1; i++) begin
              if (ge[i]) slots_next[i] = slots[i+1];
            end
            for (int i = 0; i < CAPACITY; i++) begin
              if (CW'(i) == last_idx) slots_next[i] = key_q;
            end
          end
        end
      end
      krol_pkg::OP_CLEAR: begin
        count_next = '0;
      end
      default: begin
        count_next = count;
      end
    endcase
  end

  // Pick the tail slot out of the shift line.
  always_comb begin
    tail_sel = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (CW'(i) == last_idx) tail_sel = tail_sel | slots[i];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q  <= req.opcode;
      key_q <= KEY_BITS'($unsigned(req.key));
    end
    if (cmd.compare) begin
      match_q   <= match_raw;
      tail_eq_q <= tail_eq_raw;
    end
    if (cmd.exec) begin
      slots    <= slots_next;
      status_q <= status_next;
    end
    if (cmd.publish) begin
      rsp.status      <= status_q;
      rsp.entry_count <= krol_pkg::COUNT_W'(count);
      rsp.head_key    <= empty ? '0 : $signed(krol_pkg::KEY_W'(slots[0]));
      rsp.tail_key    <= empty ? '0 : $signed(krol_pkg::KEY_W'(tail_sel));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.exec) count <= count_next;
      if (cmd.publish) rsp_valid <= 1'b1;
      else if (rsp_ready) rsp_valid <= 1'b0;
    end
  end

endmodule

// ----- src/keyed_recency_order_list.sv -----
// Keyed recency order list: an ordered list of up to CAPACITY keys (repeats
// allowed) with insert, remove, pop, move-to-end and clear operations.
//
// Request channel (req_valid / req_ready / req): one beat carries an opcode
// and a key. Response channel (rsp_valid / rsp_ready / rsp): exactly one beat
// per request, in order, with status, entry count, head key and tail key.
//
// The response shows on rsp_valid once the request beat has gone through
// capture, compare, execute and publish into the response register. Each
// request passes a compare step (every slot against the key at once) and
// an execute step (one shift of the slot line). The next request is taken
// in the execute cycle of the current one, once the response register is
// free.
//
// Reset empties the list at once; slot contents are not cleared and are
// never read beyond the entry count. A stalled response is held in its
// register; the block still takes one more request, then waits in execute
// until the response register frees up, so nothing is lost or repeated.
// Depends on krol_pkg, krol_ctrl and krol_datapath.
module keyed_recency_order_list #(
  parameter int CAPACITY = krol_pkg::CAPACITY_DEF,
  parameter int KEY_BITS = krol_pkg::KEY_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  krol_pkg::req_beat_t req,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output krol_pkg::rsp_beat_t rsp
);

  krol_pkg::krol_cmd_t cmd;
  krol_pkg::krol_sts_t sts;

  // Sequence capture, compare, execute and publish.
  krol_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_ready (rsp_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Hold the slots, the count and the response register.
  krol_datapath #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .req       (req),
    .rsp       (rsp),
    .rsp_ready (rsp_ready)
  );

  assign rsp_valid = sts.rsp_valid;

endmodule

// ----- src/krol_checker.sv -----
// Port-level checks for the keyed recency order list, bound to the top level.
// Depends on krol_pkg and keyed_recency_order_list_macros.svh.
`include "keyed_recency_order_list_macros.svh"

module krol_checker #(
  parameter int CAPACITY = krol_pkg::CAPACITY_DEF
) (
  input logic                clk,
  input logic                rst,
  input logic                req_valid,
  input logic                req_ready,
  input logic                rsp_valid,
  input logic                rsp_ready,
  input krol_pkg::rsp_beat_t rsp
);

  // A stalled response beat holds.
  `KROL_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))

  // No back-to-back requests: after a request beat the block is busy comparing.
  `KROL_ASSERT_NEXT(a_busy_after_req, req_valid && req_ready, !req_ready)

  // A rejected insert only happens on a full list.
  `KROL_ASSERT_NOW(a_full_count, rsp_valid && (rsp.status == krol_pkg::ST_FULL),
    rsp.entry_count == krol_pkg::COUNT_W'(CAPACITY))

  // An empty list reports zero keys.
  `KROL_ASSERT_NOW(a_empty_keys, rsp_valid && (CAPACITY < 32) && (rsp.entry_count == '0),
    (rsp.head_key == '0) && (rsp.tail_key == '0))

endmodule

bind keyed_recency_order_list krol_checker #(.CAPACITY(CAPACITY)) u_krol_checker (.*);

// ----- bench/keyed_recency_order_list_tb.sv -----
// Self-checking bench for keyed_recency_order_list: directed and random list operations.
// A shadow copy of the key list predicts every response beat.
// Depends on krol_pkg and the keyed_recency_order_list RTL.
module keyed_recency_order_list_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIST_CAP         = krol_pkg::CAPACITY_DEF;
  localparam int KEY_W            = krol_pkg::KEY_W;
  localparam int COUNT_W          = krol_pkg::COUNT_W;
  localparam int RANDOM_OPS       = 660;
  localparam int STRETCH_OPS      = 94;
  localparam int HOLD_OFF_CYCLES  = 300;
  localparam int RUN_LIMIT_CYCLES = 200000;

  logic                clk;
  logic                rst;
  logic                req_valid;
  logic                req_ready;
  krol_pkg::req_beat_t req;
  logic                rsp_valid;
  logic                rsp_ready;
  krol_pkg::rsp_beat_t rsp;

  // Shadow of the list: slot 0 is the head, slot shadow_len-1 the tail.
  logic [KEY_W-1:0] shadow_keys [LIST_CAP];
  int               shadow_len = 0;

  // Summaries predicted for accepted requests, oldest first.
  krol_pkg::rsp_beat_t pending_summaries [$];
  krol_pkg::rsp_beat_t want;
  int                  error_count = 0;

  // Idle controls shared by the driver, the receiver and the tests.
  bit               sender_gaps_on = 0;
  bit               receiver_stalls_on = 0;
  int               rsp_hold_request = 0;
  int unsigned      watchdog_cycles = 0;

  // Keys that random ops draw from, so removes and moves usually hit.
  logic [KEY_W-1:0] key_pool [8];

  keyed_recency_order_list dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Return the first slot holding k, or shadow_len when k is absent.
  function automatic int find_first_key(input logic [KEY_W-1:0] k);
    for (int i = 0; i < shadow_len; i++) begin
      if (shadow_keys[i] == k) return i;
    end
    return shadow_len;
  endfunction

  // Close the gap left by slot idx.
  function automatic void drop_slot(input int idx);
    for (int i = idx; i + 1 < shadow_len; i++) shadow_keys[i] = shadow_keys[i + 1];
    shadow_len--;
  endfunction

  // Apply one request to the shadow list and return the summary it produces.
  function automatic krol_pkg::rsp_beat_t apply_list_op(input krol_pkg::req_beat_t b);
    krol_pkg::rsp_beat_t s;
    logic [KEY_W-1:0]    k;
    int                  idx;
    k        = b.key;
    s.status = krol_pkg::ST_DONE;
    case (b.opcode)
      krol_pkg::OP_INS_HEAD: begin
        if (shadow_len >= LIST_CAP) begin
          s.status = krol_pkg::ST_FULL;
        end else begin
          for (int i = shadow_len; i > 0; i--) shadow_keys[i] = shadow_keys[i - 1];
          shadow_keys[0] = k;
          shadow_len++;
        end
      end
      krol_pkg::OP_INS_TAIL: begin
        if (shadow_len >= LIST_CAP) begin
          s.status = krol_pkg::ST_FULL;
        end else begin
          shadow_keys[shadow_len] = k;
          shadow_len++;
        end
      end
      krol_pkg::OP_REMOVE: begin
        idx = find_first_key(k);
        if (idx >= shadow_len) s.status = krol_pkg::ST_MISS;
        else drop_slot(idx);
      end
      krol_pkg::OP_POP_HEAD: begin
        if (shadow_len == 0) s.status = krol_pkg::ST_MISS;
        else drop_slot(0);
      end
      krol_pkg::OP_POP_TAIL: begin
        if (shadow_len == 0) s.status = krol_pkg::ST_MISS;
        else shadow_len--;
      end
      krol_pkg::OP_TO_HEAD: begin
        // A key already at the head leaves the list as it is.
        if (shadow_len == 0) begin
          s.status = krol_pkg::ST_MISS;
        end else if (shadow_keys[0] != k) begin
          idx = find_first_key(k);
          if (idx >= shadow_len) begin
            s.status = krol_pkg::ST_MISS;
          end else begin
            for (int i = idx; i > 0; i--) shadow_keys[i] = shadow_keys[i - 1];
            shadow_keys[0] = k;
          end
        end
      end
      krol_pkg::OP_TO_TAIL: begin
        // A key already at the tail is a no-op, even with a copy further up.
        if (shadow_len == 0) begin
          s.status = krol_pkg::ST_MISS;
        end else if (shadow_keys[shadow_len - 1] != k) begin
          idx = find_first_key(k);
          if (idx >= shadow_len) begin
            s.status = krol_pkg::ST_MISS;
          end else begin
            drop_slot(idx);
            shadow_keys[shadow_len] = k;
            shadow_len++;
          end
        end
      end
      default: begin
        shadow_len = 0;
      end
    endcase
    s.entry_count = shadow_len[COUNT_W-1:0];
    s.head_key    = (shadow_len == 0) ? '0 : shadow_keys[0];
    s.tail_key    = (shadow_len == 0) ? '0 : shadow_keys[shadow_len - 1];
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking: sample both channels at the edge, retire the response first,
  // then predict the request taken at the same edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_valid && rsp_ready) begin
        if (pending_summaries.size() == 0) begin
          $display("%0t: response beat with no request waiting: %p", $time, rsp);
          error_count++;
        end else begin
          want = pending_summaries.pop_front();
          if (rsp.status !== want.status) begin
            $display("%0t: status expected %0d got %0d", $time, want.status, rsp.status);
            error_count++;
          end
          if (rsp.entry_count !== want.entry_count) begin
            $display("%0t: entry_count expected %0d got %0d", $time, want.entry_count,
                     rsp.entry_count);
            error_count++;
          end
          if (rsp.head_key !== want.head_key) begin
            $display("%0t: head_key expected %h got %h", $time, want.head_key, rsp.head_key);
            error_count++;
          end
          if (rsp.tail_key !== want.tail_key) begin
            $display("%0t: tail_key expected %h got %h", $time, want.tail_key, rsp.tail_key);
            error_count++;
          end
        end
      end
      if (req_valid && req_ready) pending_summaries.push_back(apply_list_op(req));
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: draw a stall per beat, or take a long hold-off when a test asks.
  // Lower ready only when a stall follows, so it never drops and rises in one step.
  // ---------------------------------------------------------------------------
  initial begin : drain_responses
    int stall;
    rsp_ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (rsp_hold_request > 0) begin
        stall = rsp_hold_request;
        rsp_hold_request = 0;
      end else begin
        stall = receiver_stalls_on ? $urandom_range(0, 11) : 0;
      end
      if (stall > 0) begin
        rsp_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ready <= 1'b1;
      do @(posedge clk); while (!rsp_valid);
    end
  end

  // Stop a hung run.
  initial begin : watchdog
    while (watchdog_cycles < RUN_LIMIT_CYCLES) begin
      @(posedge clk);
      watchdog_cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Driver helpers
  // ---------------------------------------------------------------------------

  // Offer one request beat and hold it until taken. Valid stays high on return,
  // so a back-to-back beat follows without a dip unless a sender gap is drawn.
  task automatic send_beat(input krol_pkg::opcode_t op, input logic [KEY_W-1:0] k);
    int gap;
    gap = sender_gaps_on ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= '{opcode: op, key: k};
    do @(posedge clk); while (!req_ready);
  endtask

  // Drop valid and wait until every predicted summary has come back.
  task automatic wait_list_idle();
    req_valid <= 1'b0;
    do @(posedge clk); while (pending_summaries.size() != 0);
  endtask

  // Refill the key pool; slot 0 always carries one of the extreme keys.
  task automatic refresh_key_pool();
    case ($urandom_range(0, 3))
      0:       key_pool[0] = 32'h0000_0000;
      1:       key_pool[0] = 32'hFFFF_FFFF;
      2:       key_pool[0] = 32'h7FFF_FFFF;
      default: key_pool[0] = 32'h8000_0000;
    endcase
    for (int i = 1; i < 8; i++) key_pool[i] = $urandom;
  endtask

  // One random op, weighted so the list fills up, drains and refills.
  task automatic send_random_op();
    int                pick;
    int                ins_share;
    krol_pkg::opcode_t op;
    logic [KEY_W-1:0]  k;
    ins_share = (shadow_len >= LIST_CAP - 2) ? 25 : 48;
    pick      = $urandom_range(0, 99);
    k         = ($urandom_range(0, 3) == 0) ? $urandom : key_pool[$urandom_range(0, 7)];
    if (pick < ins_share) begin
      op = ($urandom_range(0, 1) != 0) ? krol_pkg::OP_INS_HEAD : krol_pkg::OP_INS_TAIL;
    end else if (pick < 97) begin
      case ($urandom_range(0, 4))
        0:       op = krol_pkg::OP_REMOVE;
        1:       op = krol_pkg::OP_POP_HEAD;
        2:       op = krol_pkg::OP_POP_TAIL;
        3:       op = krol_pkg::OP_TO_HEAD;
        default: op = krol_pkg::OP_TO_TAIL;
      endcase
    end else begin
      op = krol_pkg::OP_CLEAR;
    end
    // Aim some moves at the current ends to hit the no-op paths.
    if ((op == krol_pkg::OP_TO_HEAD || op == krol_pkg::OP_TO_TAIL) && shadow_len > 0 &&
        $urandom_range(0, 4) == 0) begin
      k = ($urandom_range(0, 1) != 0) ? shadow_keys[0] : shadow_keys[shadow_len - 1];
    end
    send_beat(op, k);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Every op that needs an entry must miss on the empty list; clear still succeeds.
  task automatic test_empty_list();
    send_beat(krol_pkg::OP_POP_HEAD, 32'h0000_0005);
    send_beat(krol_pkg::OP_POP_TAIL, 32'hFFFF_FFFF);
    send_beat(krol_pkg::OP_REMOVE,   32'h0000_0005);
    send_beat(krol_pkg::OP_TO_HEAD,  32'h0000_0005);
    send_beat(krol_pkg::OP_TO_TAIL,  32'h0000_0005);
    send_beat(krol_pkg::OP_CLEAR,    32'h8000_0000);
    wait_list_idle();
  endtask

  // Extreme keys, repeats, moves from the middle and from either end, misses.
  task automatic test_insert_and_move();
    send_beat(krol_pkg::OP_INS_HEAD, 32'h7FFF_FFFF);
    send_beat(krol_pkg::OP_INS_TAIL, 32'h8000_0000);
    send_beat(krol_pkg::OP_INS_HEAD, 32'hFFFF_FFFF);
    send_beat(krol_pkg::OP_INS_TAIL, 32'h0000_0000);
    send_beat(krol_pkg::OP_INS_TAIL, 32'h7FFF_FFFF);   // repeat of a key further up
    send_beat(krol_pkg::OP_TO_HEAD,  32'hFFFF_FFFF);   // already at the head
    send_beat(krol_pkg::OP_TO_TAIL,  32'h7FFF_FFFF);   // at the tail with a copy above
    send_beat(krol_pkg::OP_TO_HEAD,  32'h0000_0000);   // from the middle
    send_beat(krol_pkg::OP_TO_TAIL,  32'hFFFF_FFFF);
    send_beat(krol_pkg::OP_TO_HEAD,  32'h0001_2345);   // absent
    send_beat(krol_pkg::OP_REMOVE,   32'h7FFF_FFFF);   // first of two copies
    send_beat(krol_pkg::OP_REMOVE,   32'h0000_55AA);   // absent
    send_beat(krol_pkg::OP_TO_TAIL,  32'h8000_0000);
    send_beat(krol_pkg::OP_POP_HEAD, 32'h0000_0000);
    send_beat(krol_pkg::OP_POP_TAIL, 32'h0000_0000);
    send_beat(krol_pkg::OP_REMOVE,   32'hFFFF_FFFF);
    send_beat(krol_pkg::OP_REMOVE,   32'h7FFF_FFFF);   // list empty again
    send_beat(krol_pkg::OP_INS_HEAD, 32'h0000_002A);
    send_beat(krol_pkg::OP_CLEAR,    32'h0000_0000);
    wait_list_idle();
  endtask

  // Fill to capacity, check rejected inserts and ops on the full list.
  task automatic test_full_list();
    logic [KEY_W-1:0] fill_keys [LIST_CAP];
    sender_gaps_on     = 1;
    receiver_stalls_on = 1;
    for (int i = 0; i < LIST_CAP; i++) begin
      fill_keys[i] = $urandom;
      send_beat((i % 2 != 0) ? krol_pkg::OP_INS_TAIL : krol_pkg::OP_INS_HEAD, fill_keys[i]);
    end
    send_beat(krol_pkg::OP_INS_HEAD, $urandom);
    send_beat(krol_pkg::OP_INS_TAIL, $urandom);
    send_beat(krol_pkg::OP_TO_HEAD,  fill_keys[LIST_CAP - 1]);
    send_beat(krol_pkg::OP_TO_TAIL,  fill_keys[LIST_CAP - 2]);
    send_beat(krol_pkg::OP_REMOVE,   fill_keys[7]);
    send_beat(krol_pkg::OP_INS_TAIL, $urandom);
    send_beat(krol_pkg::OP_INS_HEAD, $urandom);
    send_beat(krol_pkg::OP_CLEAR,    $urandom);
    wait_list_idle();
  endtask

  // Hold the receiver off while beats keep coming, so the block stalls its input.
  task automatic test_backpressure();
    sender_gaps_on     = 0;
    receiver_stalls_on = 0;
    refresh_key_pool();
    rsp_hold_request = HOLD_OFF_CYCLES;
    repeat (40) send_random_op();
    wait_list_idle();
  endtask

  // Long random mix in stretches: both sides idle, neither, sender only, receiver only.
  task automatic test_random_mix();
    int stretch;
    for (int n = 0; n < RANDOM_OPS; n++) begin
      if (n % STRETCH_OPS == 0) begin
        stretch            = (n / STRETCH_OPS) % 4;
        sender_gaps_on     = (stretch == 0) || (stretch == 2);
        receiver_stalls_on = (stretch == 0) || (stretch == 3);
        refresh_key_pool();
      end
      send_random_op();
    end
    wait_list_idle();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst       <= 1'b1;
    req_valid <= 1'b0;
    req       <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_empty_list();
    test_insert_and_move();
    test_full_list();
    test_backpressure();
    test_random_mix();

    // Let any stray response show up before judging.
    wait_list_idle();
    repeat (12) @(posedge clk);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
